### src/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
`define SPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMP(label, ante, cons)
`define SPQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and the ordering relation.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 64;

    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_TOP  = 2'd2,
        FN_INC  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_NOT_HIGHER = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REL_LE = 2'd0,
        REL_LT = 2'd1,
        REL_GE = 2'd2,
        REL_GT = 2'd3
    } rel_t;

    typedef enum logic [2:0] {
        IDX_HOLD  = 3'd0,
        IDX_ZERO  = 3'd1,
        IDX_INC   = 3'd2,
        IDX_DEC   = 3'd3,
        IDX_COUNT = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load_in;
        idx_op_t idx_op;
        logic    pos_idx;
        logic    pos_count;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_new;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cap_head;
        logic    cap_old;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } spq_cmd_t;

    typedef struct packed {
        logic  count_zero;
        logic  full;
        func_t func;
        logic  rel_hit;
        logic  elem_hit;
        logic  idx_last;
        logic  idx_at_pos;
        logic  out_free;
    } spq_stat_t;

    function automatic logic rel_holds(input rel_t mode, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        logic r;
        case (mode)
            REL_LE:  r = (a <= b);
            REL_LT:  r = (a < b);
            REL_GE:  r = (a >= b);
            REL_GT:  r = (a > b);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences scan, shift and result steps for each operation.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_DISPATCH   = 14'b00000000000010,
        S_PUSH_START = 14'b00000000000100,
        S_LOC_RD     = 14'b00000000001000,
        S_LOC_EV     = 14'b00000000010000,
        S_SH_RD      = 14'b00000000100000,
        S_SH_WR      = 14'b00000001000000,
        S_FIND_RD    = 14'b00000010000000,
        S_FIND_EV    = 14'b00000100000000,
        S_RM_RD      = 14'b00001000000000,
        S_RM_WR      = 14'b00010000000000,
        S_HEAD_RD    = 14'b00100000000000,
        S_HEAD_EV    = 14'b01000000000000,
        S_FIN        = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.idx_op  = IDX_HOLD;
        cmd.rd_sel  = RD_IDX;
        cmd.status_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.func)
                    FN_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_PUSH_START;
                        end
                    end
                    FN_POP, FN_TOP:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_HEAD_RD;
                        end
                    end
                    FN_INC:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_FOUND;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_FIND_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_PUSH_START:
            begin
                cmd.idx_op = IDX_ZERO;
                if (stat.count_zero)
                begin
                    cmd.pos_count = 1'b1;
                    state_next    = S_SH_RD;
                end
                else
                begin
                    state_next = S_LOC_RD;
                end
            end
            S_LOC_RD:
            begin
                state_next = S_LOC_EV;
            end
            S_LOC_EV:
            begin
                if (stat.rel_hit)
                begin
                    cmd.pos_idx = 1'b1;
                    cmd.idx_op  = IDX_COUNT;
                    state_next  = S_SH_RD;
                end
                else if (stat.idx_last)
                begin
                    cmd.pos_count = 1'b1;
                    cmd.idx_op    = IDX_COUNT;
                    state_next    = S_SH_RD;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_LOC_RD;
                end
            end
            S_SH_RD:
            begin
                cmd.rd_sel = RD_PREV;
                if (stat.idx_at_pos)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_SH_RD;
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_EV;
            end
            S_FIND_EV:
            begin
                if (stat.elem_hit)
                begin
                    if (stat.rel_hit)
                    begin
                        cmd.cap_old = 1'b1;
                        state_next  = S_RM_RD;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOT_HIGHER;
                        state_next      = S_FIN;
                    end
                end
                else if (stat.idx_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_FIND_RD;
                end
            end
            S_RM_RD:
            begin
                cmd.rd_sel = RD_NEXT;
                if (stat.idx_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = (stat.func == FN_POP) ? S_FIN : S_PUSH_START;
                end
                else
                begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_RM_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_EV;
            end
            S_HEAD_EV:
            begin
                cmd.cap_head = 1'b1;
                state_next   = (stat.func == FN_POP) ? S_RM_RD : S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/spq_dp.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry memory, count, scan index, request and result registers.
// ----------------------------------------------------------------------------
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic [1:0]         func,
    input  logic signed [31:0] elem,
    input  logic signed [31:0] priority_req,
    input  spq_cmd_t           cmd,
    output spq_stat_t          stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] out_elem,
    output logic signed [31:0] out_priority,
    output logic signed [31:0] old_priority,
    output logic               is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] elem_mem [CAPACITY];
    logic [31:0] prio_mem [CAPACITY];

    rel_t               mode_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      pos_reg;
    func_t              func_reg;
    logic signed [31:0] req_elem_reg;
    logic signed [31:0] req_prio_reg;
    logic signed [31:0] rd_elem_reg;
    logic signed [31:0] rd_prio_reg;
    status_t            res_status_reg;
    logic signed [31:0] res_elem_reg;
    logic signed [31:0] res_prio_reg;
    logic signed [31:0] res_old_reg;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic signed [31:0] out_elem_reg;
    logic signed [31:0] out_prio_reg;
    logic signed [31:0] out_old_reg;
    logic               out_empty_reg;
    logic [CW-1:0]      rd_addr_full;
    logic [CW-1:0]      idx_plus;

    assign idx_plus = idx_reg + CW'(1);

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_INC:   idx_next = idx_plus;
            IDX_DEC:   idx_next = idx_reg - CW'(1);
            IDX_COUNT: idx_next = count_reg;
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_addr_full = idx_reg - CW'(1);
            RD_NEXT: rd_addr_full = idx_plus;
            default: rd_addr_full = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_elem_reg <= elem_mem[rd_addr_full[AW-1:0]];
        rd_prio_reg <= prio_mem[rd_addr_full[AW-1:0]];
        if (cmd.wr_en)
        begin
            elem_mem[idx_reg[AW-1:0]] <= cmd.wr_new ? req_elem_reg : rd_elem_reg;
            prio_mem[idx_reg[AW-1:0]] <= cmd.wr_new ? req_prio_reg : rd_prio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= REL_LE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= rel_t'(cfg_wr_data);
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.pos_idx)
        begin
            pos_reg <= idx_reg;
        end
        else if (cmd.pos_count)
        begin
            pos_reg <= count_reg;
        end
        if (cmd.load_in)
        begin
            func_reg       <= func_t'(func);
            req_elem_reg   <= elem;
            req_prio_reg   <= priority_req;
            res_status_reg <= ST_OK;
            res_elem_reg   <= '0;
            res_prio_reg   <= '0;
            res_old_reg    <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.cap_head)
            begin
                res_elem_reg <= rd_elem_reg;
                res_prio_reg <= rd_prio_reg;
            end
            if (cmd.cap_old)
            begin
                res_old_reg <= rd_prio_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_elem_reg   <= res_elem_reg;
            out_prio_reg   <= res_prio_reg;
            out_old_reg    <= res_old_reg;
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.func       = func_reg;
    assign stat.rel_hit    = rel_holds(mode_reg, req_prio_reg, rd_prio_reg);
    assign stat.elem_hit   = (rd_elem_reg == req_elem_reg);
    assign stat.idx_last   = (idx_plus == count_reg);
    assign stat.idx_at_pos = (idx_reg == pos_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_elem     = out_elem_reg;
    assign out_priority = out_prio_reg;
    assign old_priority = out_old_reg;
    assign is_empty     = out_empty_reg;

endmodule

### src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Ordered list of (element, priority) pairs with push, pop, top and
// increase-priority under a configurable ordering relation.
// ----------------------------------------------------------------------------
// Input beats (func, elem, priority_req) are taken on in_valid/in_ready; one
// result beat per input comes out on out_valid/out_ready. cfg_wr_en writes
// the 2-bit ordering relation; write it only while the queue is idle.
// The list lives in a single-port-write, registered-read memory walked by a
// shared index, a read state and an evaluate or write state per entry:
//   push: scan to the insert point, then shift entries up to make room
//   pop:  read the head, then shift the remaining entries down
//   top:  head read only; errors found without a scan (empty, full) go to the result
//   increase: find scan, then remove and re-insert as above
// Throughput is one operation at a time; a new beat is taken once the
// previous result sits in the output register. If the receiver stalls, the
// next operation runs and then holds until the output register frees up.
// Reset empties the queue and sets the relation to less-or-equal; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] elem,
    input  logic signed [31:0] priority_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] out_elem,
    output logic signed [31:0] out_priority,
    output logic signed [31:0] old_priority,
    output logic               is_empty
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .func         (func),
        .elem         (elem),
        .priority_req (priority_req),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_elem     (out_elem),
        .out_priority (out_priority),
        .old_priority (old_priority),
        .is_empty     (is_empty)
    );

    `SPQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `SPQ_ASSERT_IMP(a_full_not_empty, out_valid && (status == ST_FULL), !is_empty)
    `SPQ_ASSERT_IMP(a_empty_flag, out_valid && (status == ST_EMPTY), is_empty)
    `SPQ_ASSERT_IMP(a_no_inc_and_dec, cmd.cnt_inc, !cmd.cnt_dec)

endmodule

### bench/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push, pop, top and increase-priority beats under every ordering
// relation, keeps a shadow ordered list to predict each result beat, and
// compares the results field by field in arrival order.
// ----------------------------------------------------------------------------

class spq_scoreboard;
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_elem;
        logic signed [31:0] out_priority;
        logic signed [31:0] old_priority;
        logic               is_empty;
    } spq_result_t;

    logic signed [31:0] list_elem[$];
    logic signed [31:0] list_prio[$];
    spq_pkg::rel_t      mode;
    spq_result_t        pending[$];
    int                 mismatches;

    function new();
        mode = spq_pkg::REL_LE;
        mismatches = 0;
    endfunction

    function bit ordered(logic signed [31:0] a, logic signed [31:0] b);
        bit r;
        case (mode)
            spq_pkg::REL_LE: r = (a <= b);
            spq_pkg::REL_LT: r = (a < b);
            spq_pkg::REL_GE: r = (a >= b);
            default:         r = (a > b);
        endcase
        return r;
    endfunction

    function void place(logic signed [31:0] e, logic signed [31:0] p);
        int pos;
        pos = list_prio.size();
        for (int i = 0; i < list_prio.size(); i++)
        begin
            if (ordered(p, list_prio[i]))
            begin
                pos = i;
                break;
            end
        end
        list_elem.insert(pos, e);
        list_prio.insert(pos, p);
    endfunction

    function void note_input(logic [1:0] fn, logic signed [31:0] e, logic signed [31:0] p);
        spq_result_t r;
        int pos;
        r = '0;
        r.status = spq_pkg::ST_OK;
        case (fn)
            spq_pkg::FN_PUSH:
            begin
                if (list_prio.size() >= spq_pkg::SPQ_CAPACITY) r.status = spq_pkg::ST_FULL;
                else place(e, p);
            end
            spq_pkg::FN_POP, spq_pkg::FN_TOP:
            begin
                if (list_prio.size() == 0) r.status = spq_pkg::ST_EMPTY;
                else
                begin
                    r.out_elem = list_elem[0];
                    r.out_priority = list_prio[0];
                    if (fn == spq_pkg::FN_POP)
                    begin
                        list_elem.delete(0);
                        list_prio.delete(0);
                    end
                end
            end
            default:
            begin
                pos = -1;
                for (int i = 0; i < list_elem.size(); i++)
                begin
                    if (list_elem[i] == e)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos < 0) r.status = spq_pkg::ST_NOT_FOUND;
                else if (!ordered(p, list_prio[pos])) r.status = spq_pkg::ST_NOT_HIGHER;
                else
                begin
                    r.old_priority = list_prio[pos];
                    list_elem.delete(pos);
                    list_prio.delete(pos);
                    place(e, p);
                end
            end
        endcase
        r.is_empty = (list_prio.size() == 0);
        pending.push_back(r);
    endfunction

    function void check_result(spq_result_t got);
        spq_result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected st=%0d e=%0d p=%0d old=%0d emp=%0d,",
                          " got st=%0d e=%0d p=%0d old=%0d emp=%0d"},
                         want.status, want.out_elem, want.out_priority, want.old_priority,
                         want.is_empty, got.status, got.out_elem, got.out_priority,
                         got.old_priority, got.is_empty);
        end
    endfunction
endclass

module sorted_priority_queue_tb;
    import spq_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = '0;
    logic signed [31:0] elem = '0;
    logic signed [31:0] priority_req = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] out_elem;
    logic signed [31:0] out_priority;
    logic signed [31:0] old_priority;
    logic               is_empty;

    spq_scoreboard board;
    bit                 hold_off_req = 0;
    bit                 hold_off_done = 0;

    sorted_priority_queue dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .elem(elem),
        .priority_req(priority_req), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .out_elem(out_elem), .out_priority(out_priority),
        .old_priority(old_priority), .is_empty(is_empty)
    );

    always #5 clk = ~clk;

    task automatic send_beat(logic [1:0] fn, logic signed [31:0] e, logic signed [31:0] p);
        func <= fn;
        elem <= e;
        priority_req <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        board.note_input(fn, e, p);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_relation(rel_t m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.mode = m;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = $urandom;
            default: v = $signed($urandom_range(0, 15)) - 8;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pick_elem();
        logic signed [31:0] v;
        if ($urandom_range(0, 9) == 0) v = $urandom;
        else if (board.list_elem.size() != 0 && $urandom_range(0, 3) != 0)
            v = board.list_elem[$urandom_range(0, board.list_elem.size() - 1)];
        else v = $signed($urandom_range(0, 23));
        return v;
    endfunction

    task automatic random_phase(int count, int push_weight);
        int gap;
        int burst;
        logic [1:0] fn;
        int r;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    go_idle();
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 20);
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < push_weight) fn = FN_PUSH;
            else if (r < push_weight + 15) fn = FN_POP;
            else if (r < push_weight + 25) fn = FN_TOP;
            else fn = FN_INC;
            send_beat(fn, pick_elem(), pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({status, out_elem, out_priority, old_priority, is_empty});
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off_done = 1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 15) == 0) stall = $urandom_range(1, 12);
            end
        end
    end

    initial
    begin
        #50ms;
        $display("sorted_priority_queue test failed");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(FN_POP, 0, 0);
        send_beat(FN_TOP, 0, 0);
        send_beat(FN_INC, 5, 5);
        send_beat(FN_PUSH, 32'sh7fffffff, 32'sh80000000);
        send_beat(FN_PUSH, 32'sh80000000, 32'sh7fffffff);
        send_beat(FN_PUSH, 32'shffffffff, 0);
        send_beat(FN_PUSH, 0, 0);
        send_beat(FN_TOP, 0, 0);
        send_beat(FN_INC, 32'sh80000000, 32'sh80000000);
        send_beat(FN_INC, 0, 32'sh7fffffff);
        send_beat(FN_INC, 0, 0);
        send_beat(FN_INC, 32'sh12345678, 1);
        send_beat(FN_POP, 0, 0);
        send_beat(FN_POP, 0, 0);
        send_beat(FN_POP, 0, 0);
        send_beat(FN_POP, 0, 0);
        send_beat(FN_POP, 0, 0);
        for (int i = 0; i < SPQ_CAPACITY; i++) send_beat(FN_PUSH, i, $signed(i % 5));
        send_beat(FN_PUSH, 99, 1);
        send_beat(FN_INC, 7, 32'sh80000000);
        send_beat(FN_PUSH, 98, 2);
        drain();

        for (int m = 0; m < 4; m++)
        begin
            set_relation(rel_t'(m));
            random_phase(120, 30);
            drain();
            if (m == 1) hold_off_req = 1;
            random_phase(120, 60);
            drain();
        end
        set_relation(REL_GT);
        random_phase(60, 40);
        drain();
        set_relation(REL_LE);
        random_phase(60, 40);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("sorted_priority_queue test passed");
        else
            $display("sorted_priority_queue test failed");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
